@@ rtl/dj5_pkg.sv @@
// Shared widths, register indexes and constants of the damped Jacobi sweep unit.
package dj5_pkg;

   localparam int VALUE_W    = 32;
   localparam int ACC_W      = 67;
   localparam int DIM_W      = 11;
   localparam int OMEGA_W    = 18;
   localparam int ROW_W      = 10;
   localparam int MAX_ROWS   = 1024;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA       = 2'd2;

   localparam logic [DIM_W-1:0]   GRID_WIDTH_RESET  = 11'd1024;
   localparam logic [DIM_W-1:0]   GRID_HEIGHT_RESET = 11'd1024;
   localparam logic [OMEGA_W-1:0] OMEGA_RESET       = 18'd43691;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic [VALUE_W-1:0] source;
      logic [VALUE_W-1:0] center;
      logic [VALUE_W-1:0] west;
   } coef_word_type;

endpackage

@@ rtl/dj5_ifs.sv @@
// Handshake channel interfaces: grid point input, update output, register write.
interface dj5_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [dj5_pkg::VALUE_W-1:0]  old_value;
   logic signed [dj5_pkg::VALUE_W-1:0]  source_value;
   logic signed [dj5_pkg::VALUE_W-1:0]  center_coef;
   logic signed [dj5_pkg::VALUE_W-1:0]  west_coef;
   logic signed [dj5_pkg::VALUE_W-1:0]  south_coef;
   modport source (output valid, old_value, source_value, center_coef, west_coef,
                   south_coef, input ready);
   modport sink (input valid, old_value, source_value, center_coef, west_coef,
                 south_coef, output ready);
endinterface

interface dj5_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dj5_pkg::VALUE_W-1:0]  new_value;
   logic                                last_point;
   modport source (output valid, new_value, last_point, input ready);
   modport sink (input valid, new_value, last_point, output ready);
endinterface

interface dj5_csr_if;
   logic                               valid;
   logic                               ready;
   logic [dj5_pkg::CSR_IDX_W-1:0]      index;
   logic [dj5_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/damped_jacobi_five_point_sweep_unit.sv @@
// Damped Jacobi five-point sweep unit: top level with line stores and update sequencer.
//
// Grid points enter on req_port in raster order, one word per point carrying the old
// value, source term and the center, west and south coefficients. Updated interior
// points leave on rsp_port, one row and one point behind the input; last_point marks
// the final interior point. Boundary points give no output word.
// Registers on csr_port (index 0 grid width, 1 grid height, 2 omega) take effect on
// the next point; the user must write them only while the unit is idle, and the unit
// does not enforce this. csr_port is always ready. Each point passes through line
// store access (two reads of the value memory through its single read port, then
// write back). An interior point then goes through the shared 32x32 multiplier
// (S_MUL, S_SUM), the bit-serial divider (with a short path when the center is zero
// or the quotient overflows 32 unsigned bits) and damping and rounding (S_SCALE,
// S_ROUND). A point is accepted only between points.
// The output word sits in its own register, so the next point is taken while a
// result waits; a finished update waits for that register while rsp_port stalls.
// Reset clears the position counters, loads the register defaults and empties the
// output; the line stores hold no meaningful data until the first rows pass.
module damped_jacobi_five_point_sweep_unit #(
   parameter int MAX_ROW_LENGTH = 1024
) (
   input  logic     clock,
   input  logic     reset,
   dj5_req_if.sink  req_port,
   dj5_rsp_if.source rsp_port,
   dj5_csr_if.sink  csr_port
);

   localparam int VW   = dj5_pkg::VALUE_W;
   localparam int NW   = dj5_pkg::ACC_W;
   localparam int DW   = dj5_pkg::DIM_W;
   localparam int RW   = dj5_pkg::ROW_W;
   localparam int OW   = dj5_pkg::OMEGA_W;
   localparam int CW   = $clog2(MAX_ROW_LENGTH);
   localparam int LW   = CW + 1;
   localparam int CMPW = (LW > DW) ? LW : DW;
   localparam int AW   = $clog2(2 * MAX_ROW_LENGTH);
   localparam int SW   = VW + 1 + OW + 1;
   localparam int RNDW = SW - 16;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_FETCH, S_MUL, S_SUM, S_DIV, S_WAIT, S_SCALE, S_ROUND
   } state_type;

   state_type               state_ff;
   logic [DW-1:0]           width_ff;
   logic [DW-1:0]           height_ff;
   logic [OW-1:0]           omega_ff;
   logic [CW-1:0]           col_ff;
   logic [RW-1:0]           row_ff;

   logic [VW-1:0]           u_ff, f_ff, cc_ff, w_ff, s_ff;
   logic [CW-1:0]           caddr_ff;
   logic [AW-1:0]           cur_addr_ff, prv_addr_ff;
   logic                    interior_ff, last_ff;
   logic [VW-1:0]           du_ff, sprv_ff, df_ff, dc_ff, dw_ff;
   logic [VW-1:0]           up1_ff, up2_ff, hu_ff, lu_ff, ls_ff, sp1_ff;
   logic [VW-1:0]           hw_ff, hf_ff, hc_ff;
   logic signed [VW-1:0]    opa_ff [4];
   logic signed [VW-1:0]    opb_ff [4];
   logic signed [VW-1:0]    uc_ff, den_ff, z_ff;
   logic signed [NW-1:0]    acc_ff;
   logic signed [2*VW-1:0]  prod_ff;
   logic [1:0]              idx_ff;
   logic signed [SW-1:0]    scale_ff;
   logic                    rsp_valid_ff, rsp_last_ff;
   logic [VW-1:0]           rsp_value_ff;

   logic [CMPW-1:0]         width_wide;
   logic [LW-1:0]           w_lim;
   logic [DW-1:0]           h_lim;
   logic [CW-1:0]           pos_c;
   logic [RW-1:0]           pos_r;
   logic [DW-1:0]           row_step;
   logic [LW-1:0]           col_next;
   logic [DW-1:0]           row_next;
   logic [CW-1:0]           col_in;
   logic [RW-1:0]           row_in;
   logic [AW-1:0]           cur_addr, prv_addr;
   logic                    req_fire, out_free;

   logic                    vram_re, vram_we, sram_we, cram_we;
   logic [AW-1:0]           vram_raddr;
   logic [VW-1:0]           vram_rdata, sram_rdata;
   dj5_pkg::coef_word_type  cram_wdata, cram_rdata;

   logic                    div_start, div_done;
   logic signed [VW-1:0]    div_quot;

   logic signed [RNDW-1:0]  rounded;
   logic signed [RNDW:0]    upd_sum;
   logic [VW-1:0]           upd_sat;

   // Grid size clamp and raster position
   always_comb begin
      width_wide = CMPW'(width_ff);
      if (width_wide < CMPW'(3)) begin
         w_lim = LW'(3);
      end else if (width_wide > CMPW'(MAX_ROW_LENGTH)) begin
         w_lim = LW'(MAX_ROW_LENGTH);
      end else begin
         w_lim = LW'(width_wide);
      end
      if (height_ff < DW'(3)) begin
         h_lim = DW'(3);
      end else if (height_ff > DW'(dj5_pkg::MAX_ROWS)) begin
         h_lim = DW'(dj5_pkg::MAX_ROWS);
      end else begin
         h_lim = height_ff;
      end

      if (LW'(col_ff) >= w_lim) begin
         pos_c    = '0;
         row_step = DW'(row_ff) + DW'(1);
      end else begin
         pos_c    = col_ff;
         row_step = DW'(row_ff);
      end
      pos_r = (row_step >= h_lim) ? '0 : row_step[RW-1:0];

      col_next = LW'(pos_c) + LW'(1);
      row_next = DW'(pos_r) + DW'(1);
      if (col_next >= w_lim) begin
         col_in = '0;
         row_in = (row_next >= h_lim) ? '0 : row_next[RW-1:0];
      end else begin
         col_in = col_next[CW-1:0];
         row_in = pos_r;
      end

      cur_addr = pos_r[0] ? (AW'(MAX_ROW_LENGTH) + AW'(pos_c)) : AW'(pos_c);
      prv_addr = pos_r[0] ? AW'(pos_c) : (AW'(MAX_ROW_LENGTH) + AW'(pos_c));
   end

   assign req_fire       = req_port.valid && req_port.ready;
   assign req_port.ready = state_ff == S_IDLE;
   assign csr_port.ready = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   // Line store access
   assign vram_re    = req_fire || (state_ff == S_READ);
   assign vram_raddr = (state_ff == S_READ) ? prv_addr_ff : cur_addr;
   assign vram_we    = state_ff == S_FETCH;
   assign sram_we    = state_ff == S_FETCH;
   assign cram_we    = state_ff == S_FETCH;
   assign cram_wdata = '{source: f_ff, center: cc_ff, west: w_ff};

   dj5_ram #(.DEPTH(2 * MAX_ROW_LENGTH), .WIDTH(VW)) u_value_ram (
      .clock (clock),
      .we    (vram_we),
      .waddr (cur_addr_ff),
      .wdata (u_ff),
      .re    (vram_re),
      .raddr (vram_raddr),
      .rdata (vram_rdata)
   );

   dj5_ram #(.DEPTH(2 * MAX_ROW_LENGTH), .WIDTH(VW)) u_south_ram (
      .clock (clock),
      .we    (sram_we),
      .waddr (cur_addr_ff),
      .wdata (s_ff),
      .re    (req_fire),
      .raddr (prv_addr),
      .rdata (sram_rdata)
   );

   dj5_ram #(.DEPTH(MAX_ROW_LENGTH), .WIDTH($bits(dj5_pkg::coef_word_type))) u_coef_ram (
      .clock (clock),
      .we    (cram_we),
      .waddr (caddr_ff),
      .wdata (cram_wdata),
      .re    (req_fire),
      .raddr (pos_c),
      .rdata (cram_rdata)
   );

   assign div_start = state_ff == S_DIV;

   dj5_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Damping, rounding and saturation
   always_comb begin
      rounded = RNDW'((scale_ff + SW'(32768)) >>> 16);
      upd_sum = (RNDW+1)'(uc_ff) + (RNDW+1)'(rounded);
      if (upd_sum > (RNDW+1)'($signed(dj5_pkg::VALUE_MAX))) begin
         upd_sat = dj5_pkg::VALUE_MAX;
      end else if (upd_sum < (RNDW+1)'($signed(dj5_pkg::VALUE_MIN))) begin
         upd_sat = dj5_pkg::VALUE_MIN;
      end else begin
         upd_sat = upd_sum[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dj5_pkg::GRID_WIDTH_RESET;
         height_ff <= dj5_pkg::GRID_HEIGHT_RESET;
         omega_ff  <= dj5_pkg::OMEGA_RESET;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            dj5_pkg::CSR_GRID_WIDTH:  width_ff  <= csr_port.data[DW-1:0];
            dj5_pkg::CSR_GRID_HEIGHT: height_ff <= csr_port.data[DW-1:0];
            dj5_pkg::CSR_OMEGA:       omega_ff  <= csr_port.data[OW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if ((state_ff == S_ROUND) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  u_ff        <= req_port.old_value;
                  f_ff        <= req_port.source_value;
                  cc_ff       <= req_port.center_coef;
                  w_ff        <= req_port.west_coef;
                  s_ff        <= req_port.south_coef;
                  caddr_ff    <= pos_c;
                  cur_addr_ff <= cur_addr;
                  prv_addr_ff <= prv_addr;
                  interior_ff <= (pos_c >= CW'(2)) && (pos_r >= RW'(2));
                  last_ff     <= (LW'(pos_c) == w_lim - LW'(1)) &&
                                 (DW'(pos_r) == h_lim - DW'(1));
                  col_ff      <= col_in;
                  row_ff      <= row_in;
                  state_ff    <= S_READ;
               end
            end
            S_READ: begin
               du_ff    <= vram_rdata;
               sprv_ff  <= sram_rdata;
               df_ff    <= cram_rdata.source;
               dc_ff    <= cram_rdata.center;
               dw_ff    <= cram_rdata.west;
               state_ff <= S_FETCH;
            end
            S_FETCH: begin
               opa_ff[0] <= hw_ff;
               opb_ff[0] <= up2_ff;
               opa_ff[1] <= dw_ff;
               opb_ff[1] <= vram_rdata;
               opa_ff[2] <= sp1_ff;
               opb_ff[2] <= hu_ff;
               opa_ff[3] <= ls_ff;
               opb_ff[3] <= lu_ff;
               acc_ff    <= $signed({{(NW-VW-16){hf_ff[VW-1]}}, hf_ff, 16'b0});
               den_ff    <= hc_ff;
               uc_ff     <= up1_ff;
               up2_ff    <= up1_ff;
               up1_ff    <= vram_rdata;
               hu_ff     <= du_ff;
               lu_ff     <= u_ff;
               ls_ff     <= s_ff;
               sp1_ff    <= sprv_ff;
               hw_ff     <= dw_ff;
               hf_ff     <= df_ff;
               hc_ff     <= dc_ff;
               idx_ff    <= '0;
               state_ff  <= interior_ff ? S_MUL : S_IDLE;
            end
            S_MUL: begin
               prod_ff <= opa_ff[idx_ff] * opb_ff[idx_ff];
               if (idx_ff != 2'd0) begin
                  acc_ff <= acc_ff + NW'(prod_ff);
               end
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               acc_ff   <= acc_ff + NW'(prod_ff);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (div_done) begin
                  z_ff     <= div_quot;
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               scale_ff <= SW'(((VW+1)'(z_ff) - (VW+1)'(uc_ff)) *
                               $signed({1'b0, omega_ff}));
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               if (out_free) begin
                  rsp_value_ff <= upd_sat;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.new_value  = rsp_value_ff;
   assign rsp_port.last_point = rsp_last_ff;

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_READ)
      else $error("accepted word did not start line store read");

   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_WAIT)
      else $error("divider finished with no update waiting");

   a_hold_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) && !out_free |=> state_ff == S_ROUND)
      else $error("update dropped while output stalled");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      vram_we |-> $past(state_ff) == S_READ)
      else $error("line store written before both reads");

endmodule

@@ rtl/dj5_ram.sv @@
// Simple dual-port line store memory with registered read data.
module dj5_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/dj5_div.sv @@
// Iterative saturating divider: wide signed sum over signed coefficient, one bit a cycle.
module dj5_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [dj5_pkg::ACC_W-1:0]    num,
   input  logic signed [dj5_pkg::VALUE_W-1:0]  den,
   output logic                                done,
   output logic signed [dj5_pkg::VALUE_W-1:0]  quot
);

   localparam int VW = dj5_pkg::VALUE_W;
   localparam int NW = dj5_pkg::ACC_W;
   localparam int KW = $clog2(VW);

   typedef enum logic [2:0] {D_IDLE, D_ABS, D_CHK, D_ITER, D_SAT} div_state_type;

   div_state_type     state_ff;
   logic [NW-1:0]     num_ff;
   logic [VW-1:0]     den_ff;
   logic [NW-1:0]     mag_ff;
   logic [VW-1:0]     dmag_ff;
   logic              neg_ff;
   logic              dneg_ff;
   logic              dzero_ff;
   logic [VW-1:0]     rem_ff;
   logic [VW-1:0]     quo_ff;
   logic [KW-1:0]     cnt_ff;
   logic [VW-1:0]     quot_ff;
   logic              done_ff;

   logic [VW:0]       trial;
   logic              trial_ge;
   logic [VW:0]       trial_diff;
   logic              ovf;

   always_comb begin
      trial      = {rem_ff, quo_ff[VW-1]};
      trial_ge   = trial >= {1'b0, dmag_ff};
      trial_diff = trial - {1'b0, dmag_ff};
      ovf        = mag_ff >= NW'({dmag_ff, {VW{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  num_ff   <= num;
                  den_ff   <= den;
                  state_ff <= D_ABS;
               end
            end
            D_ABS: begin
               neg_ff   <= num_ff[NW-1];
               mag_ff   <= num_ff[NW-1] ? (~num_ff + NW'(1)) : num_ff;
               dneg_ff  <= den_ff[VW-1];
               dmag_ff  <= den_ff[VW-1] ? (~den_ff + VW'(1)) : den_ff;
               dzero_ff <= den_ff == '0;
               state_ff <= D_CHK;
            end
            D_CHK: begin
               if (dzero_ff) begin
                  quot_ff  <= (mag_ff == '0) ? '0 :
                              (neg_ff ? dj5_pkg::VALUE_MIN : dj5_pkg::VALUE_MAX);
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else if (ovf) begin
                  quot_ff  <= (neg_ff ^ dneg_ff) ? dj5_pkg::VALUE_MIN : dj5_pkg::VALUE_MAX;
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  neg_ff   <= neg_ff ^ dneg_ff;
                  rem_ff   <= mag_ff[2*VW-1:VW];
                  quo_ff   <= mag_ff[VW-1:0];
                  cnt_ff   <= '0;
                  state_ff <= D_ITER;
               end
            end
            D_ITER: begin
               rem_ff <= trial_ge ? trial_diff[VW-1:0] : trial[VW-1:0];
               quo_ff <= {quo_ff[VW-2:0], trial_ge};
               cnt_ff <= cnt_ff + KW'(1);
               if (cnt_ff == KW'(VW-1)) begin
                  state_ff <= D_SAT;
               end
            end
            D_SAT: begin
               if (neg_ff) begin
                  quot_ff <= (quo_ff > dj5_pkg::VALUE_MIN) ? dj5_pkg::VALUE_MIN
                                                           : (~quo_ff + VW'(1));
               end else begin
                  quot_ff <= quo_ff[VW-1] ? dj5_pkg::VALUE_MAX : quo_ff;
               end
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ bench/damped_jacobi_five_point_sweep_unit_test.sv @@
// Self-checking bench for the damped Jacobi five-point sweep unit with a scoreboard.
module damped_jacobi_five_point_sweep_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [dj5_pkg::VALUE_W-1:0] new_value;
      logic                        last_point;
   } update_type;

   class sweep_scoreboard;
      update_type           pending_updates[$];
      int                   errors;
      int                   updates_checked;
      int unsigned          width_reg, height_reg, omega_reg;
      logic signed [31:0]   value_lines[2048];
      logic signed [31:0]   south_lines[2048];
      logic signed [31:0]   source_line[1024];
      logic signed [31:0]   center_line[1024];
      logic signed [31:0]   west_line[1024];
      logic signed [31:0]   lag_u, lag_f, lag_c, lag_w;
      int unsigned          col, row;

      function new();
         width_reg  = dj5_pkg::GRID_WIDTH_RESET;
         height_reg = dj5_pkg::GRID_HEIGHT_RESET;
         omega_reg  = dj5_pkg::OMEGA_RESET;
         foreach (value_lines[k]) begin
            value_lines[k] = '0;
            south_lines[k] = '0;
         end
         foreach (source_line[k]) begin
            source_line[k] = '0;
            center_line[k] = '0;
            west_line[k] = '0;
         end
         lag_u = '0; lag_f = '0; lag_c = '0; lag_w = '0;
         col = 0; row = 0;
      endfunction

      function void write_register(logic [dj5_pkg::CSR_IDX_W-1:0] idx,
                                   logic [dj5_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            dj5_pkg::CSR_GRID_WIDTH:  width_reg = data[dj5_pkg::DIM_W-1:0];
            dj5_pkg::CSR_GRID_HEIGHT: height_reg = data[dj5_pkg::DIM_W-1:0];
            dj5_pkg::CSR_OMEGA:       omega_reg = data[dj5_pkg::OMEGA_W-1:0];
            default: ;
         endcase
      endfunction

      function void report_mismatch(string what);
         errors++;
         $display("mismatch: %s", what);
      endfunction

      function void note_point(logic signed [31:0] u, logic signed [31:0] f,
                               logic signed [31:0] cc, logic signed [31:0] w,
                               logic signed [31:0] s);
         int unsigned wd, ht, c, r, cur, prv;
         logic signed [31:0] du, df, dc, dw, uw, uc, ue, us, un, sc, sn;
         logic signed [69:0] acc;
         logic [69:0] mag;
         logic [63:0] dmag, q;
         bit neg, big;
         longint z, v, res;
         update_type upd;
         wd = (width_reg < 3) ? 3 : ((width_reg > 1024) ? 1024 : width_reg);
         ht = (height_reg < 3) ? 3 :
              ((height_reg > dj5_pkg::MAX_ROWS) ? dj5_pkg::MAX_ROWS : height_reg);
         if (col >= wd) begin
            col = 0;
            row++;
         end
         if (row >= ht) row = 0;
         c = col; r = row;
         cur = (r & 1) * 1024;
         prv = ((r & 1) ^ 1) * 1024;
         du = value_lines[cur + c];
         df = source_line[c]; dc = center_line[c]; dw = west_line[c];
         if (c >= 2 && r >= 2) begin
            uw = value_lines[prv + c - 2]; uc = value_lines[prv + c - 1];
            ue = value_lines[prv + c]; us = lag_u; un = value_lines[cur + c - 1];
            sc = south_lines[prv + c - 1]; sn = south_lines[cur + c - 1];
            acc = longint'(lag_w) * longint'(uw);
            acc = acc + longint'(dw) * longint'(ue);
            acc = acc + longint'(sc) * longint'(us);
            acc = acc + longint'(sn) * longint'(un);
            acc = acc + (longint'(lag_f) <<< 16);
            neg = acc[69];
            mag = neg ? -acc : acc;
            big = (mag[69:63] != 0);
            if (lag_c == 0) begin
               if (!big && mag == 0) z = 0;
               else z = neg ? -64'sd2147483648 : 64'sd2147483647;
            end else begin
               if (lag_c < 0) begin
                  neg = !neg;
                  dmag = -longint'(lag_c);
               end else begin
                  dmag = longint'(lag_c);
               end
               if (big) begin
                  z = neg ? -64'sd2147483648 : 64'sd2147483647;
               end else begin
                  q = mag[63:0] / dmag;
                  if (neg) z = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
                  else z = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
               end
            end
            v = (z - longint'(uc)) * longint'(omega_reg) + 32768;
            res = longint'(uc) + (v >>> 16);
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            upd.new_value = res[31:0];
            upd.last_point = (c == wd - 1 && r == ht - 1);
            pending_updates.push_back(upd);
         end
         value_lines[cur + c] = u;
         south_lines[cur + c] = s;
         source_line[c] = f; center_line[c] = cc; west_line[c] = w;
         lag_u = du; lag_f = df; lag_c = dc; lag_w = dw;
         col = c + 1;
         if (col >= wd) begin
            col = 0;
            row = r + 1;
            if (row >= ht) row = 0;
         end
      endfunction

      function void check_update(logic [dj5_pkg::VALUE_W-1:0] value, logic last);
         update_type want;
         if (pending_updates.size() == 0) begin
            report_mismatch($sformatf("unexpected word value=%h last=%b", value, last));
            return;
         end
         want = pending_updates.pop_front();
         updates_checked++;
         if (value !== want.new_value)
            report_mismatch($sformatf("new_value got %h want %h", value, want.new_value));
         if (last !== want.last_point)
            report_mismatch($sformatf("last_point got %b want %b", last, want.last_point));
      endfunction
   endclass

   logic clock;
   logic reset;
   dj5_req_if req();
   dj5_rsp_if rsp();
   dj5_csr_if csr();

   damped_jacobi_five_point_sweep_unit dut (
      .clock(clock), .reset(reset), .req_port(req), .rsp_port(rsp), .csr_port(csr)
   );

   sweep_scoreboard board = new();
   int  hold_off_cycles = 0;
   bit  quiet = 0;
   int  points_sent = 0;
   int  grids_run = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   // receiver: random stalls plus requested long hold-off
   initial begin
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp.ready <= 0;
         end else if (quiet) begin
            rsp.ready <= 1;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 199) == 0) hold_off_cycles = $urandom_range(20, 80);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            board.note_point(req.old_value, req.source_value, req.center_coef,
                             req.west_coef, req.south_coef);
         if (rsp.valid && rsp.ready)
            board.check_update(rsp.new_value, rsp.last_point);
      end
   end

   task automatic write_csr(logic [dj5_pkg::CSR_IDX_W-1:0] idx,
                            logic [dj5_pkg::CSR_DATA_W-1:0] data);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data  <= data;
      do @(posedge clock); while (!csr.ready);
      board.write_register(idx, data);
      @(negedge clock);
      csr.valid <= 0;
      @(negedge clock);
   endtask

   task automatic send_point(logic [31:0] u, logic [31:0] f, logic [31:0] cc,
                             logic [31:0] w, logic [31:0] s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1;
      req.old_value <= u;
      req.source_value <= f;
      req.center_coef <= cc;
      req.west_coef <= w;
      req.south_coef <= s;
      do @(posedge clock); while (!req.ready);
      points_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (board.pending_updates.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic setup_grid(int unsigned wd, int unsigned ht, int unsigned om);
      write_csr(dj5_pkg::CSR_GRID_WIDTH, dj5_pkg::CSR_DATA_W'(wd));
      write_csr(dj5_pkg::CSR_GRID_HEIGHT, dj5_pkg::CSR_DATA_W'(ht));
      write_csr(dj5_pkg::CSR_OMEGA, dj5_pkg::CSR_DATA_W'(om));
      grids_run++;
   endtask

   function automatic logic [31:0] any_word(logic [31:0] typical);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return $urandom();
      if (roll < 16) return dj5_pkg::VALUE_MAX;
      if (roll < 20) return dj5_pkg::VALUE_MIN;
      if (roll < 23) return '0;
      return typical;
   endfunction

   task automatic send_random_grid(int unsigned wd, int unsigned ht);
      int unsigned wc, hc;
      logic [31:0] u, f, cc, w, s;
      wc = (wd < 3) ? 3 : ((wd > 1024) ? 1024 : wd);
      hc = (ht < 3) ? 3 : ((ht > 1024) ? 1024 : ht);
      repeat (wc * hc) begin
         u  = any_word($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         f  = any_word($signed($urandom_range(0, 1 << 18)) - (1 << 17));
         cc = any_word(32'h0004_0000 + $urandom_range(0, 1 << 16) - (1 << 15));
         w  = any_word(-32'sd65536 + $signed($urandom_range(0, 1 << 14)));
         s  = any_word(-32'sd65536 + $signed($urandom_range(0, 1 << 14)));
         send_point(u, f, cc, w, s);
      end
      drain();
   endtask

   initial begin
      int unsigned om;
      req.valid = 0;
      req.old_value = '0; req.source_value = '0; req.center_coef = '0;
      req.west_coef = '0; req.south_coef = '0;
      csr.valid = 0; csr.index = dj5_pkg::CSR_GRID_WIDTH; csr.data = '0;
      reset = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // all zero with zero centre: quotient stays zero
      setup_grid(0, 1, 0);
      repeat (9) send_point('0, '0, '0, '0, '0);
      drain();
      // zero centre with nonzero sum saturates, omega at two
      setup_grid(3, 3, 131072);
      for (int k = 0; k < 9; k++)
         send_point('0, (k == 4) ? dj5_pkg::VALUE_MAX : '0, '0, '0, '0);
      drain();
      // extreme field values, omega above two
      setup_grid(2, 2, 262143);
      for (int k = 0; k < 9; k++) begin
         if (k[0]) send_point(dj5_pkg::VALUE_MAX, dj5_pkg::VALUE_MIN, dj5_pkg::VALUE_MAX,
                              dj5_pkg::VALUE_MIN, dj5_pkg::VALUE_MAX);
         else send_point(dj5_pkg::VALUE_MIN, dj5_pkg::VALUE_MAX, 32'hffff_ffff,
                         dj5_pkg::VALUE_MAX, dj5_pkg::VALUE_MIN);
      end
      drain();

      while (points_sent < 700) begin
         case ($urandom_range(0, 3))
            0: om = 0;
            1: om = 131072;
            2: om = dj5_pkg::OMEGA_RESET;
            default: om = $urandom_range(0, 262143);
         endcase
         quiet = ($urandom_range(0, 4) == 0);
         setup_grid($urandom_range(0, 12), $urandom_range(0, 9), om);
         if (grids_run == 6) hold_off_cycles = 3000;
         send_random_grid(board.width_reg, board.height_reg);
      end
      quiet = 0;

      if (board.pending_updates.size() != 0)
         board.report_mismatch("updates never delivered");
      $display("covered %0d grids, %0d points in, %0d updates checked",
               grids_run, points_sent, board.updates_checked);
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
